@@ sv/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/tpes_pkg.sv @@
// ----------------------------------------------------------------------------
// tpes_pkg
// Shared constants and codes for the timed profile event scheduler.
// ----------------------------------------------------------------------------
package tpes_pkg;

  localparam int TableDepthDef = 256;
  localparam int MaxTracesDef  = 16;
  localparam int TimeBitsDef   = 32;

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncAdd   = 2'd1;
  localparam logic [1:0] FuncPop   = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatNotDue  = 2'd1;
  localparam logic [1:0] StatNoSlot  = 2'd2;
  localparam logic [1:0] StatEmpty   = 2'd3;

endpackage

@@ sv/timed_profile_event_scheduler.sv @@
// ----------------------------------------------------------------------------
// timed_profile_event_scheduler
// Profile table plus trace slots; pops earliest due event per request.
// ----------------------------------------------------------------------------
// Each request is handled by a sequencer that scans the trace slots one per
// cycle with a single compare unit. Steps from the accepting edge to the
// result: a table write, an unused func or an empty-profile add runs the
// earliest-due scan; an add runs the free-slot scan, then the earliest-due
// scan; a pop runs the earliest scan, table address, registered read,
// update and earliest rescan, or only the earliest scan and rescan when
// nothing is due. The table has one write port and one read port with
// registered read data. Input stall is high whenever a request is in
// progress or a result waits in the output register, so the next request
// is not taken before the result has been accepted.
module timed_profile_event_scheduler
  import tpes_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int MAX_TRACES  = MaxTracesDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [7:0]         table_addr_i,
  input  logic [31:0]        entry_delay_i,
  input  logic signed [31:0] entry_value_i,
  input  logic [7:0]         profile_base_i,
  input  logic [8:0]         profile_len_i,
  input  logic [7:0]         resource_id_i,
  input  logic [31:0]        query_date_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [3:0]         handle_o,
  output logic [7:0]         out_resource_o,
  output logic signed [31:0] out_value_o,
  output logic               finished_o,
  output logic               next_valid_o,
  output logic [31:0]        next_due_o
);
  `include "assert_macros.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = (MAX_TRACES > 1) ? $clog2(MAX_TRACES) : 1;
  localparam int CW = $clog2(MAX_TRACES + 1);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = TIME_BITS;
  localparam logic [TW-1:0] TMax = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_FREE, S_BEST, S_READ, S_UPD, S_NEXT, S_OUT
  } state_e;

  logic [TW-1:0] tbl_delay [TABLE_DEPTH];
  logic [31:0]   tbl_value [TABLE_DEPTH];

  logic [MAX_TRACES-1:0] valid_q;
  logic [TW-1:0]  due_q  [MAX_TRACES];
  logic [LW-1:0]  idx_q  [MAX_TRACES];
  logic [7:0]     base_q [MAX_TRACES];
  logic [LW-1:0]  len_q  [MAX_TRACES];
  logic [7:0]     res_q  [MAX_TRACES];

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sel_q;
  logic          found_q;
  logic [7:0]    pbase_q, pres_q;
  logic [LW-1:0] plen_q;
  logic [TW-1:0] query_q;
  logic [TW-1:0] rd_delay_q;
  logic [31:0]   rd_value_q;
  logic [AW-1:0] raddr_q;

  logic [1:0]  status_q;
  logic [3:0]  handle_q;
  logic [7:0]  ores_q;
  logic [31:0] oval_q;
  logic        fin_q, nvalid_q, ovalid_q;
  logic [31:0] ndue_q;

  logic [SW-1:0] ci;
  logic [TW:0]   sum;
  logic [TW-1:0] sat;
  logic [LW:0]   idx1;
  logic [LW-1:0] len_in;
  logic [8:0]    len_sat;

  assign ci   = cnt_q[SW-1:0];
  assign sum  = {1'b0, due_q[sel_q]} + {1'b0, rd_delay_q};
  assign sat  = sum[TW] ? TMax : sum[TW-1:0];
  assign idx1 = {1'b0, idx_q[sel_q]} + 1'b1;
  assign len_sat = (32'(profile_len_i) > 32'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH)
                                                           : profile_len_i;
  assign len_in = LW'(len_sat);

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !in_stall_o && func_i == FuncWrite) begin
      tbl_delay[AW'(table_addr_i)] <= TW'(entry_delay_i);
      tbl_value[AW'(table_addr_i)] <= entry_value_i;
    end
    rd_delay_q <= tbl_delay[raddr_q];
    rd_value_q <= tbl_value[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      sel_q    <= '0;
      found_q  <= 1'b0;
      pbase_q  <= '0;
      pres_q   <= '0;
      plen_q   <= '0;
      query_q  <= '0;
      raddr_q  <= '0;
      status_q <= StatOk;
      handle_q <= '0;
      ores_q   <= '0;
      oval_q   <= '0;
      fin_q    <= 1'b0;
      nvalid_q <= 1'b0;
      ndue_q   <= '0;
      for (int i = 0; i < MAX_TRACES; i++) begin
        due_q[i]  <= '0;
        idx_q[i]  <= '0;
        base_q[i] <= '0;
        len_q[i]  <= '0;
        res_q[i]  <= '0;
      end
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            pbase_q  <= profile_base_i;
            plen_q   <= len_in;
            pres_q   <= resource_id_i;
            query_q  <= TW'(query_date_i);
            status_q <= (func_i == FuncAdd && len_sat == '0) ? StatEmpty : StatOk;
            handle_q <= '0;
            ores_q   <= '0;
            oval_q   <= '0;
            fin_q    <= 1'b0;
            cnt_q    <= '0;
            found_q  <= 1'b0;
            sel_q    <= '0;
            if (func_i == FuncAdd && len_sat == '0) begin
              state_q  <= S_NEXT;
            end else if (func_i == FuncAdd) begin
              state_q <= S_FREE;
            end else if (func_i == FuncPop) begin
              state_q <= S_BEST;
            end else begin
              state_q <= S_NEXT;
            end
          end
        end
        S_FREE: begin
          if (!valid_q[ci]) begin
            valid_q[ci] <= 1'b1;
            due_q[ci]   <= '0;
            idx_q[ci]   <= '0;
            base_q[ci]  <= pbase_q;
            len_q[ci]   <= plen_q;
            res_q[ci]   <= pres_q;
            handle_q    <= 4'(ci);
            cnt_q       <= '0;
            state_q     <= S_NEXT;
          end else if (cnt_q == CW'(MAX_TRACES - 1)) begin
            status_q <= StatNoSlot;
            cnt_q    <= '0;
            state_q  <= S_NEXT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_BEST, S_NEXT: begin
          if (valid_q[ci] && (!found_q || due_q[ci] < due_q[sel_q])) begin
            sel_q   <= ci;
            found_q <= 1'b1;
          end
          if (cnt_q == CW'(MAX_TRACES - 1)) begin
            cnt_q <= '0;
            if (state_q == S_NEXT) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_READ;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_READ: begin
          if (!found_q || due_q[sel_q] > query_q) begin
            status_q <= StatNotDue;
            found_q  <= 1'b0;
            sel_q    <= '0;
            state_q  <= S_NEXT;
          end else begin
            raddr_q <= AW'({1'b0, base_q[sel_q]} + 9'(idx_q[sel_q]));
            state_q <= S_UPD;
            cnt_q   <= CW'(1);
          end
        end
        S_UPD: begin
          if (cnt_q != '0) begin
            cnt_q <= '0;
          end else begin
            handle_q <= 4'(sel_q);
            ores_q   <= res_q[sel_q];
            oval_q   <= rd_value_q;
            if (idx1 < {1'b0, len_q[sel_q]}) begin
              due_q[sel_q] <= sat;
              idx_q[sel_q] <= idx1[LW-1:0];
            end else if (rd_delay_q != '0) begin
              due_q[sel_q] <= sat;
              idx_q[sel_q] <= (len_q[sel_q] > LW'(1)) ? LW'(1) : '0;
            end else begin
              valid_q[sel_q] <= 1'b0;
              fin_q <= 1'b1;
            end
            found_q <= 1'b0;
            sel_q   <= '0;
            state_q <= S_NEXT;
          end
        end
        S_OUT: begin
          nvalid_q <= found_q;
          ndue_q   <= found_q ? 32'(due_q[sel_q]) : '0;
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE) || ovalid_q;
  assign out_valid_o    = ovalid_q;
  assign status_o       = status_q;
  assign handle_o       = handle_q;
  assign out_resource_o = ores_q;
  assign out_value_o    = oval_q;
  assign finished_o     = fin_q;
  assign next_valid_o   = nvalid_q;
  assign next_due_o     = ndue_q;

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, in_stall_o)
  `ASSERT_NEXT(a_out_after_scan, clk_i, rst_ni, state_q == S_OUT, out_valid_o)
  `ASSERT_IMPL(a_next_valid_any, clk_i, rst_ni, out_valid_o && next_valid_o,
               valid_q != '0)
endmodule
